// ----- rtl/core/bap_pkg.sv -----
// Shared types and constants for the bond angle pipeline.
// No dependencies; bond_angle_three_points imports this package.
package bap_pkg;

	localparam int CORDIC_STEPS = 28;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [32:0] diff_t;
	typedef logic signed [30:0] norm_t;

	// atan(2^-i) * 2^30, truncated except the last entry, which is rounded up.
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// Scales a vector so its largest magnitude lies in [2^29, 2^30).
	// Left shifts are exact; right shifts truncate magnitudes towards zero.
	function automatic logic [92:0] normalize(input diff_t a, input diff_t b,
			input diff_t c);
		logic [32:0] ma, mb, mc, m, sa, sb, sc;
		logic [2:0] neg;
		logic [5:0] lz;
		logic [92:0] r;
		ma = a[32] ? 33'(-a) : 33'(a);
		mb = b[32] ? 33'(-b) : 33'(b);
		mc = c[32] ? 33'(-c) : 33'(c);
		neg = {a[32], b[32], c[32]};
		m = ma | mb | mc;
		lz = 6'd0;
		for (int k = 0; k < 33; k++) begin
			if (m[k]) lz = 6'(k);
		end
		if (lz >= 6'd30) begin
			sa = ma >> (lz - 6'd29);
			sb = mb >> (lz - 6'd29);
			sc = mc >> (lz - 6'd29);
		end else begin
			sa = ma << (6'd29 - lz);
			sb = mb << (6'd29 - lz);
			sc = mc << (6'd29 - lz);
		end
		r[92:62] = neg[2] ? 31'(-sa) : sa[30:0];
		r[61:31] = neg[1] ? 31'(-sb) : sb[30:0];
		r[30:0]  = neg[0] ? 31'(-sc) : sc[30:0];
		return r;
	endfunction

endpackage

// ----- rtl/core/bap_if.sv -----
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; used by bond_angle_three_points.
interface bap_if #(parameter int W = 1) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/bond_angle_three_points.sv -----
// Bond angle at a vertex from three 3-D points, fully pipelined.
// Depends on bap_pkg and the bap_if channel interface.
//
// Use: the input channel carries one word of nine signed Q15.16
// coordinates packed as {end1 xyz, vertex xyz, end2 xyz}, end1_x in the
// top bits. The output channel returns one word per input word:
// {angle_rad, degenerate}, angle in unsigned Q2.FRAC_BITS radians.
// From acceptance to the result standing valid, a word passes through
// differences, normalisation, three product stages, the square root
// (one stage per result bit, 32), the 28 CORDIC stages and rounding,
// which share the pipeline. Throughput is one word per cycle while the
// receiver does not stall; every stage is one register of the chain.
// The whole pipeline advances together on a single enable: when the
// receiver stalls with a valid result at the output, nothing moves and
// input ready falls, so no word is lost or repeated; bubbles are filled
// while the head is free.
// Reset clears every valid bit; payload registers are not reset.
// A vector with all differences zero gives degenerate = 1, angle 0.
module bond_angle_three_points #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	bap_if.sink   in_ch,
	bap_if.source out_ch
);
	import bap_pkg::*;

	localparam int AW = FRAC_BITS + 2;
	localparam int SQ = 32;                // square root stages
	localparam int NS = CORDIC_STEPS;
	localparam int DEPTH = 5 + SQ + NS + 1;

	logic adv;
	logic [DEPTH-1:0] vld_q;
	assign adv = !vld_q[DEPTH-1] || out_ch.ready;
	assign in_ch.ready = adv;

	coord_t p [9];
	always_comb begin
		for (int k = 0; k < 9; k++) p[k] = coord_t'(in_ch.data[32*(8-k) +: 32]);
	end

	// s1: differences
	diff_t u_s1 [3], v_s1 [3];
	always_ff @(posedge clk) if (adv) begin
		for (int k = 0; k < 3; k++) begin
			u_s1[k] <= diff_t'(p[k]) - diff_t'(p[3+k]);
			v_s1[k] <= diff_t'(p[6+k]) - diff_t'(p[3+k]);
		end
	end

	// s2: normalisation
	norm_t u_s2 [3], w_s2 [3];
	logic dg_s2;
	logic [92:0] nu, nv;
	assign nu = normalize(u_s1[0], u_s1[1], u_s1[2]);
	assign nv = normalize(v_s1[0], v_s1[1], v_s1[2]);
	always_ff @(posedge clk) if (adv) begin
		for (int k = 0; k < 3; k++) begin
			u_s2[k] <= nu[31*(2-k) +: 31];
			w_s2[k] <= nv[31*(2-k) +: 31];
		end
		dg_s2 <= (u_s1[0] == '0 && u_s1[1] == '0 && u_s1[2] == '0) ||
			(v_s1[0] == '0 && v_s1[1] == '0 && v_s1[2] == '0);
	end

	// s3: nine products
	logic signed [61:0] pr_s3 [9];
	logic dg_s3;
	always_ff @(posedge clk) if (adv) begin
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++) pr_s3[3*a+b] <= u_s2[a] * w_s2[b];
		dg_s3 <= dg_s2;
	end

	// s4: dot and cross sums, cross magnitudes shifted down by 30
	logic signed [63:0] d_s4;
	logic [32:0] cm_s4 [3];
	logic dg_s4;
	logic signed [63:0] cr [3];
	always_comb begin
		cr[0] = 64'(pr_s3[5]) - 64'(pr_s3[7]);
		cr[1] = 64'(pr_s3[6]) - 64'(pr_s3[2]);
		cr[2] = 64'(pr_s3[1]) - 64'(pr_s3[3]);
	end
	always_ff @(posedge clk) if (adv) begin
		d_s4 <= 64'(pr_s3[0]) + 64'(pr_s3[4]) + 64'(pr_s3[8]);
		for (int k = 0; k < 3; k++) begin
			logic [63:0] m;
			m = cr[k][63] ? 64'(-cr[k]) : 64'(cr[k]);
			cm_s4[k] <= 33'(m >> 30);
		end
		dg_s4 <= dg_s3;
	end

	// s5: squares summed (each square under 2^64 / 3)
	logic [65:0] sum_s5;
	logic [32:0] xm_s5;
	logic dneg_s5, dg_s5;
	logic [63:0] dmag;
	assign dmag = d_s4[63] ? 64'(-d_s4) : 64'(d_s4);
	always_ff @(posedge clk) if (adv) begin
		sum_s5 <= 66'(cm_s4[0]) * 66'(cm_s4[0]) + 66'(cm_s4[1]) * 66'(cm_s4[1])
			+ 66'(cm_s4[2]) * 66'(cm_s4[2]);
		xm_s5 <= 33'(dmag >> 30);
		dneg_s5 <= d_s4[63];
		dg_s5 <= dg_s4;
	end

	// square root, one result bit per stage (restoring)
	logic [65:0] rem_q [SQ+1];
	logic [32:0] root_q [SQ+1];
	logic [32:0] xq_q [SQ+1];
	logic dn_q [SQ+1], dgq_q [SQ+1];
	always_comb begin
		rem_q[0] = sum_s5; root_q[0] = '0; xq_q[0] = xm_s5;
		dn_q[0] = dneg_s5; dgq_q[0] = dg_s5;
	end
	genvar g;
	generate
		for (g = 0; g < SQ; g++) begin : g_sqrt
			logic [65:0] trial;
			logic [32:0] cand;
			assign cand = root_q[g] | (33'd1 << (SQ-1-g));
			assign trial = 66'(cand) * 66'(cand);
			always_ff @(posedge clk) if (adv) begin
				root_q[g+1] <= (trial <= rem_q[g]) ? cand : root_q[g];
				rem_q[g+1] <= rem_q[g];
				xq_q[g+1] <= xq_q[g]; dn_q[g+1] <= dn_q[g]; dgq_q[g+1] <= dgq_q[g];
			end
		end
	endgenerate

	// CORDIC vectoring, one step per stage
	logic signed [35:0] cx_q [NS+1], cy_q [NS+1];
	logic signed [33:0] cz_q [NS+1];
	logic cdn_q [NS+1], cdg_q [NS+1];
	always_comb begin
		cx_q[0] = 36'(xq_q[SQ]); cy_q[0] = 36'(root_q[SQ]); cz_q[0] = '0;
		cdn_q[0] = dn_q[SQ]; cdg_q[0] = dgq_q[SQ];
	end
	generate
		for (g = 0; g < NS; g++) begin : g_cordic
			logic signed [35:0] xs, ys;
			assign xs = cx_q[g] >>> g;
			assign ys = cy_q[g] >>> g;
			always_ff @(posedge clk) if (adv) begin
				if (cy_q[g] > 0) begin
					cx_q[g+1] <= cx_q[g] + ys;
					cy_q[g+1] <= cy_q[g] - xs;
					cz_q[g+1] <= cz_q[g] + 34'(atan_q30(5'(g)));
				end else begin
					cx_q[g+1] <= cx_q[g] - ys;
					cy_q[g+1] <= cy_q[g] + xs;
					cz_q[g+1] <= cz_q[g] - 34'(atan_q30(5'(g)));
				end
				cdn_q[g+1] <= cdn_q[g]; cdg_q[g+1] <= cdg_q[g];
			end
		end
	endgenerate

	// final: clamp, quadrant fold and rounding
	logic [31:0] zc, zf, zr;
	logic [AW-1:0] ang_q;
	logic dg_q;
	always_comb begin
		if (cz_q[NS] < 0) zc = '0;
		else if (cz_q[NS] > 34'(HALF_PI_Q30)) zc = HALF_PI_Q30;
		else zc = 32'(cz_q[NS]);
		zf = cdn_q[NS] ? PI_Q30 - zc : zc;
		zr = 32'((33'(zf) + (33'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
	end
	always_ff @(posedge clk) if (adv) begin
		ang_q <= cdg_q[NS] ? '0 : zr[AW-1:0];
		dg_q <= cdg_q[NS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
	end

	assign out_ch.valid = vld_q[DEPTH-1];
	assign out_ch.data = {ang_q, dg_q};

`ifndef ASSERT_OFF
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready) else $error("ready low with free head");
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && dg_q |-> ang_q == '0) else $error("degenerate angle nonzero");
`endif
endmodule
